// ===== sv/stbc_pkg.sv =====
// Package for the sixteen-bit four-register core: transaction types, codes, states.
// No dependencies.
package stbc_pkg;

  localparam int MemWordsDefault = 256;
  localparam int RegCount        = 4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  address;
    logic [15:0] data;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status_code;
    logic [4:0]  cycles_used;
    logic [7:0]  pc_value;
    logic [15:0] status_word;
    logic [1:0]  io_register;
    logic [15:0] io_value;
  } rsp_t;

  // command codes
  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_EXEC    = 3'd1;
  localparam logic [2:0] CMD_READ    = 3'd2;
  localparam logic [2:0] CMD_RESTART = 3'd3;
  localparam logic [2:0] CMD_SETREG  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_BOUND = 3'd2;
  localparam logic [2:0] ST_OVF   = 3'd3;
  localparam logic [2:0] ST_UNDF  = 3'd4;
  localparam logic [2:0] ST_BADOP = 3'd5;
  localparam logic [2:0] ST_RD    = 3'd6;
  localparam logic [2:0] ST_WR    = 3'd7;

  // instruction opcodes
  localparam logic [4:0] OP_LOAD = 5'd0;
  localparam logic [4:0] OP_STOR = 5'd1;
  localparam logic [4:0] OP_ADD  = 5'd2;
  localparam logic [4:0] OP_ADC  = 5'd3;
  localparam logic [4:0] OP_SUB  = 5'd4;
  localparam logic [4:0] OP_SBC  = 5'd5;
  localparam logic [4:0] OP_AND  = 5'd6;
  localparam logic [4:0] OP_XOR  = 5'd7;
  localparam logic [4:0] OP_NOT  = 5'd8;
  localparam logic [4:0] OP_SHL  = 5'd9;
  localparam logic [4:0] OP_SHLA = 5'd10;
  localparam logic [4:0] OP_SHR  = 5'd11;
  localparam logic [4:0] OP_SHRA = 5'd12;
  localparam logic [4:0] OP_CMP  = 5'd13;
  localparam logic [4:0] OP_GETS = 5'd14;
  localparam logic [4:0] OP_PUTS = 5'd15;
  localparam logic [4:0] OP_JMP  = 5'd16;
  localparam logic [4:0] OP_JLT  = 5'd17;
  localparam logic [4:0] OP_JEQ  = 5'd18;
  localparam logic [4:0] OP_JGT  = 5'd19;
  localparam logic [4:0] OP_CALL = 5'd20;
  localparam logic [4:0] OP_RET  = 5'd21;
  localparam logic [4:0] OP_RD   = 5'd22;
  localparam logic [4:0] OP_WR   = 5'd23;
  localparam logic [4:0] OP_HALT = 5'd24;
  localparam logic [4:0] OP_NOP  = 5'd25;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_LOAD,
    S_PUSH,
    S_POP,
    S_DONE
  } state_t;

  // ALU operations of the shared unit
  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_XOR,
    ALU_NOT,
    ALU_SHL,
    ALU_SHR
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic        cin;
    logic        keep_msb;
  } alu_ctl_t;

endpackage

// ===== sv/stbc_alu.sv =====
// Shared arithmetic, logic and shift unit of the core.
// Depends on stbc_pkg.
module stbc_alu (
  input  stbc_pkg::alu_ctl_t ctl,
  input  logic [15:0]        a,
  input  logic [15:0]        b,
  output logic [15:0]        y,
  output logic               carry,
  output logic               ovf
);
  import stbc_pkg::*;

  logic [16:0] sum;

  // one adder serves add, subtract and their carry forms
  always_comb begin
    sum   = '0;
    y     = '0;
    carry = 1'b0;
    ovf   = 1'b0;
    unique case (ctl.op)
      ALU_ADD: begin
        sum   = {1'b0, a} + {1'b0, b} + {16'd0, ctl.cin};
        y     = sum[15:0];
        carry = sum[16];
        ovf   = ~(a[15] ^ b[15]) & (a[15] ^ sum[15]);
      end
      ALU_SUB: begin
        sum   = {1'b0, a} - {1'b0, b} - {16'd0, ctl.cin};
        y     = sum[15:0];
        carry = sum[16];
        ovf   = (a[15] ^ b[15]) & ~(b[15] ^ sum[15]);
      end
      ALU_AND: y = a & b;
      ALU_XOR: y = a ^ b;
      ALU_NOT: y = ~a;
      ALU_SHL: begin
        y     = ctl.keep_msb ? {a[15], a[13:0], 1'b0} : {a[14:0], 1'b0};
        carry = a[15];
      end
      ALU_SHR: begin
        y     = {ctl.keep_msb & a[15], a[15:1]};
        carry = a[0];
      end
      default: y = '0;
    endcase
  end

endmodule

// ===== sv/sixteen_bit_four_register_cpu_core_unit.sv =====
// Top level of the sixteen-bit four-register core: sequencer, registers, memory.
// Depends on stbc_pkg and stbc_alu.
//
// Channel | Signals                  | Handshake
// cmd     | start, cmd_in (cmd_t)    | accepted when start && !busy
// rsp     | done, rsp_out (rsp_t)    | one-cycle strobe, no backpressure
// cfg     | cfg_we, cfg_data         | written on any edge with cfg_we
//
// A non-execute command goes from idle straight to done, its strobe in the cycle after
// acceptance. An execute passes fetch, execute, done and idle; a load from memory adds load,
// call and return push or pop, since every memory word passes the single memory port.
// Reset is synchronous on rst: it clears registers, pc and flags, sets the stack pointer
// to the top; memory contents stay undefined until written. The receiver cannot stall.
module sixteen_bit_four_register_cpu_core_unit #(
  parameter int MEM_WORDS = stbc_pkg::MemWordsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  stbc_pkg::cmd_t cmd_in,
  output logic           busy,
  input  logic           cfg_we,
  input  logic [8:0]     cfg_data,
  output logic           done,
  output stbc_pkg::rsp_t rsp_out
);
  import stbc_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [8:0] TOP = 9'(MEM_WORDS);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rdata;
  logic        mem_we;
  logic [7:0]  mem_addr;
  logic [15:0] mem_wdata;
  logic        addr_ok;

  logic [15:0] regs [RegCount];
  logic [7:0]  pc;
  logic [8:0]  sp;
  logic [15:0] flags;
  logic [8:0]  bound;
  cmd_t        cmd;
  logic [15:0] instr;
  logic [2:0]  cnt;
  logic [2:0]  code;
  logic [4:0]  cyc;
  logic [1:0]  io_reg;
  logic [15:0] io_val;

  state_t state, state_next;

  // memory port
  assign addr_ok = ({1'b0, mem_addr} < TOP);
  always_ff @(posedge clk) begin
    if (mem_we && addr_ok) mem[mem_addr[AW-1:0]] <= mem_wdata;
    rdata <= addr_ok ? mem[mem_addr[AW-1:0]] : 16'd0;
  end

  // instruction fields
  logic [4:0]  op;
  logic [1:0]  dst, src;
  logic        imm;
  logic [7:0]  tgt;
  logic [15:0] k16, a, b;
  logic [8:0]  lim;
  logic        tgt_bad;
  logic        call_ovf;
  logic        ret_undf;
  logic [4:0]  cyc_ex;
  assign op  = instr[15:11];
  assign dst = instr[10:9];
  assign imm = instr[8];
  assign src = instr[7:6];
  assign tgt = instr[7:0];
  assign k16 = {{8{tgt[7]}}, tgt};
  assign a   = regs[dst];
  assign b   = imm ? k16 : regs[src];
  assign lim = (bound < TOP) ? bound : TOP;
  assign tgt_bad = ({1'b0, tgt} >= lim);
  // stack checks; the overflow sum needs a tenth bit for bounds near the top
  assign call_ovf = ({1'b0, sp} < ({1'b0, bound} + 10'd6));
  assign ret_undf = (sp > TOP - 9'd6);

  // cycle cost of the instruction in execute
  always_comb begin
    cyc_ex = 5'd1;
    case (op)
      OP_LOAD: if (!imm && !tgt_bad) cyc_ex = 5'd4;
      OP_STOR: if (!tgt_bad) cyc_ex = 5'd4;
      OP_CALL: if (!tgt_bad && !call_ovf) cyc_ex = 5'd4;
      OP_RET:  if (!ret_undf) cyc_ex = 5'd4;
      OP_RD, OP_WR: cyc_ex = 5'd28;
      default: ;
    endcase
  end

  // shared unit control
  alu_ctl_t    actl;
  logic [15:0] ay;
  logic        acarry, aovf;
  always_comb begin
    actl = '{op: ALU_ADD, cin: 1'b0, keep_msb: 1'b0};
    case (op)
      OP_ADC:  actl.cin = flags[0];
      OP_SUB:  actl.op = ALU_SUB;
      OP_SBC:  actl = '{op: ALU_SUB, cin: flags[0], keep_msb: 1'b0};
      OP_CMP:  actl.op = ALU_SUB;
      OP_AND:  actl.op = ALU_AND;
      OP_XOR:  actl.op = ALU_XOR;
      OP_NOT:  actl.op = ALU_NOT;
      OP_SHL:  actl.op = ALU_SHL;
      OP_SHLA: actl = '{op: ALU_SHL, cin: 1'b0, keep_msb: 1'b1};
      OP_SHR:  actl.op = ALU_SHR;
      OP_SHRA: actl = '{op: ALU_SHR, cin: 1'b0, keep_msb: 1'b1};
      default: actl.op = ALU_ADD;
    endcase
  end

  stbc_alu u_alu (.ctl(actl), .a(a), .b(b), .y(ay), .carry(acarry), .ovf(aovf));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = (cmd_in.opcode == CMD_EXEC) ? S_FETCH : S_DONE;
      S_FETCH: state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_DONE;
        if (op == OP_LOAD && !imm && !tgt_bad) state_next = S_LOAD;
        if (op == OP_CALL && !tgt_bad && !call_ovf) state_next = S_PUSH;
        if (op == OP_RET && !ret_undf) state_next = S_POP;
      end
      S_LOAD:  state_next = S_DONE;
      S_PUSH:  if (cnt == 3'd5) state_next = S_DONE;
      S_POP:   if (cnt == 3'd5) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cmd.address;
    mem_wdata = cmd.data;
    unique case (state)
      S_IDLE: begin
        // an execute reads the instruction word at pc right away
        mem_addr  = (cmd_in.opcode == CMD_EXEC) ? pc : cmd_in.address;
        mem_wdata = cmd_in.data;
        mem_we    = start && cmd_in.opcode == CMD_WRITE;
      end
      S_FETCH: mem_addr = pc;
      S_EXEC: begin
        mem_addr  = (op == OP_RET) ? sp[7:0] : tgt;
        mem_wdata = a;
        mem_we    = (op == OP_STOR) && !tgt_bad;
      end
      S_PUSH: begin
        mem_addr = 8'(sp - 9'd1);
        mem_we   = 1'b1;
        unique case (cnt)
          3'd0:    mem_wdata = {8'd0, pc};
          3'd1:    mem_wdata = regs[0];
          3'd2:    mem_wdata = regs[1];
          3'd3:    mem_wdata = regs[2];
          3'd4:    mem_wdata = regs[3];
          default: mem_wdata = flags;
        endcase
      end
      S_POP:   mem_addr = 8'(sp + 9'd1);
      default: mem_addr = cmd.address;
    endcase
  end

  // stop: put the status code in bits 7:5 and clear the upper byte
  function automatic logic [15:0] stopf(logic [15:0] f, logic [2:0] c);
    return {8'd0, c, f[4:0]};
  endfunction

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < RegCount; i++) regs[i] <= '0;
      pc    <= '0;
      sp    <= TOP;
      flags <= '0;
      bound <= 9'd256;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) bound <= cfg_data;
      unique case (state)
        S_IDLE: if (start) begin
          cmd    <= cmd_in;
          code   <= ST_OK;
          cyc    <= '0;
          io_reg <= '0;
          io_val <= '0;
          cnt    <= '0;
          if (cmd_in.opcode == CMD_RESTART) pc <= cmd_in.address;
          if (cmd_in.opcode == CMD_SETREG) regs[cmd_in.address[1:0]] <= cmd_in.data;
        end
        S_FETCH: pc <= pc + 8'd1;
        S_EXEC: begin
          instr <= instr;
          cyc   <= cyc_ex;
          case (op)
            OP_LOAD: if (imm) regs[dst] <= k16;
                     else if (tgt_bad) begin code <= ST_BOUND; flags <= stopf(flags, ST_BOUND); end
            OP_STOR: if (tgt_bad) begin code <= ST_BOUND; flags <= stopf(flags, ST_BOUND); end
            OP_ADD, OP_SUB: begin
              regs[dst] <= ay;
              flags <= {flags[15:5], aovf, flags[3:1], acarry} &
                       {aovf ? 16'hFFFF : 16'h000F} & {acarry ? 16'hFFFF : 16'h001E};
            end
            OP_ADC, OP_SBC: begin
              regs[dst] <= ay;
              flags <= acarry ? (flags | 16'h0001) : (flags & 16'h001E);
            end
            OP_AND, OP_XOR, OP_NOT: regs[dst] <= ay;
            OP_SHL, OP_SHLA, OP_SHR, OP_SHRA: begin
              regs[dst] <= ay;
              flags <= acarry ? (flags | 16'h0001) : (flags & 16'h001E);
            end
            OP_CMP: flags <= (flags & 16'h0011) |
                     {12'd0, ($signed(a) < $signed(b)), (a == b), ($signed(a) > $signed(b)), 1'b0};
            OP_GETS: regs[dst] <= flags;
            OP_PUTS: flags <= a;
            OP_JMP, OP_JLT, OP_JEQ, OP_JGT:
              if (tgt_bad) begin code <= ST_BOUND; flags <= stopf(flags, ST_BOUND); end
              else if (op == OP_JMP || (op == OP_JLT && flags[3]) ||
                       (op == OP_JEQ && flags[2]) || (op == OP_JGT && flags[1])) pc <= tgt;
            OP_CALL:
              if (tgt_bad) begin code <= ST_BOUND; flags <= stopf(flags, ST_BOUND); end
              else if (call_ovf) begin code <= ST_OVF; flags <= stopf(flags, ST_OVF); end
            OP_RET:
              if (ret_undf) begin code <= ST_UNDF; flags <= stopf(flags, ST_UNDF); end
            OP_RD: begin
              io_reg <= dst; code <= ST_RD; flags <= stopf(flags, ST_RD);
            end
            OP_WR: begin
              io_reg <= dst; io_val <= a; code <= ST_WR;
              flags <= stopf(flags, ST_WR);
            end
            OP_HALT: begin code <= ST_HALT; flags <= stopf(flags, ST_HALT); end
            OP_NOP: ;
            default: begin code <= ST_BADOP; flags <= stopf(flags, ST_BADOP); end
          endcase
        end
        S_LOAD: regs[dst] <= rdata;
        S_PUSH: begin
          sp  <= sp - 9'd1;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd5) pc <= tgt;
        end
        S_POP: begin
          // rdata holds the word at sp, read in the previous cycle
          sp  <= sp + 9'd1;
          cnt <= cnt + 3'd1;
          unique case (cnt)
            3'd0:    flags   <= rdata;
            3'd1:    regs[3] <= rdata;
            3'd2:    regs[2] <= rdata;
            3'd3:    regs[1] <= rdata;
            3'd4:    regs[0] <= rdata;
            3'd5:    pc      <= rdata[7:0];
            default: ;
          endcase
        end
        S_DONE: if (cmd.opcode == CMD_READ) io_val <= rdata;
        default: ;
      endcase
      // capture the fetched word
      if (state == S_FETCH) instr <= rdata;
      if (state == S_IDLE && start && cmd_in.opcode == CMD_EXEC) instr <= '0;
    end
  end

  // outputs
  logic [15:0] io_out;
  always_comb begin
    busy   = (state != S_IDLE);
    done   = (state == S_DONE);
    io_out = (cmd.opcode == CMD_READ) ? rdata : io_val;
    rsp_out = '{status_code: code, cycles_used: cyc, pc_value: pc,
                status_word: flags, io_register: io_reg, io_value: io_out};
  end

endmodule
